// File: sv/tfe_pkg.sv
package tfe_pkg;

    // Item kinds
    localparam logic [1:0] KIND_DATA   = 2'd0;
    localparam logic [1:0] KIND_EMPTY  = 2'd1;
    localparam logic [1:0] KIND_POLL   = 2'd2;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    // Configuration register indexes
    localparam logic REG_DATA_FRAME_ID   = 1'b0;
    localparam logic REG_POLL_START_BYTE = 1'b1;

    localparam int unsigned CFG_ADDR_W  = 3;
    localparam int unsigned CFG_DATA_W  = 32;
    localparam int unsigned QUEUE_DEPTH = 2;

    // Register reset values
    localparam logic [7:0] DATA_FRAME_ID_RST   = 8'h10;
    localparam logic [7:0] POLL_START_BYTE_RST = 8'h7E;

    // Stuffing constants
    localparam logic [7:0] FLAG_BYTE = 8'h7E;
    localparam logic [7:0] ESC_BYTE  = 8'h7D;
    localparam logic [7:0] ESC_XOR   = 8'h20;

    // Byte slot of the check byte, and of the last poll header byte
    localparam logic [2:0] CHECK_IDX     = 3'd7;
    localparam logic [2:0] POLL_LAST_IDX = 3'd1;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  sensor_id;
        logic [15:0] type_id;
        logic [31:0] value;
    } item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_byte;
    } result_t;

    // One classified frame waiting for the serializer
    typedef struct packed {
        logic            is_poll;
        logic [7:0][7:0] bytes;
    } frame_t;

endpackage

// File: sv/tfe_front.sv
module tfe_front
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    // item side
    input  logic                                 push,
    input  tfe_pkg::item_t                       item,
    input  logic                                 q_full,
    output logic                                 q_wr,
    output tfe_pkg::frame_t                      q_wr_data,
    // configuration port
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [tfe_pkg::CFG_ADDR_W-1:0]       paddr,
    input  logic [tfe_pkg::CFG_DATA_W-1:0]       pwdata,
    output logic [tfe_pkg::CFG_DATA_W-1:0]       prdata
);

    logic [7:0] data_frame_id_reg;
    logic [7:0] poll_start_byte_reg;
    logic       cfg_wr;
    logic       cfg_idx;
    logic       accept;

    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[2];

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_frame_id_reg   <= tfe_pkg::DATA_FRAME_ID_RST;
            poll_start_byte_reg <= tfe_pkg::POLL_START_BYTE_RST;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                tfe_pkg::REG_DATA_FRAME_ID:   data_frame_id_reg   <= pwdata[7:0];
                tfe_pkg::REG_POLL_START_BYTE: poll_start_byte_reg <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // Register read back
    always_comb
    begin
        prdata = '0;
        case (cfg_idx)
            tfe_pkg::REG_DATA_FRAME_ID:   prdata[7:0] = data_frame_id_reg;
            tfe_pkg::REG_POLL_START_BYTE: prdata[7:0] = poll_start_byte_reg;
            default:                      prdata      = '0;
        endcase
    end

    // Classify the beat into a frame; unused kind is dropped
    assign accept = push && !q_full;
    assign q_wr   = accept && (item.kind != tfe_pkg::KIND_UNUSED);

    always_comb
    begin
        q_wr_data = '0;
        case (item.kind)
            tfe_pkg::KIND_DATA:
            begin
                q_wr_data.bytes[0] = data_frame_id_reg;
                q_wr_data.bytes[1] = item.type_id[7:0];
                q_wr_data.bytes[2] = item.type_id[15:8];
                q_wr_data.bytes[3] = item.value[7:0];
                q_wr_data.bytes[4] = item.value[15:8];
                q_wr_data.bytes[5] = item.value[23:16];
                q_wr_data.bytes[6] = item.value[31:24];
            end
            tfe_pkg::KIND_EMPTY:
            begin
                q_wr_data.bytes[0] = data_frame_id_reg;
            end
            tfe_pkg::KIND_POLL:
            begin
                q_wr_data.is_poll  = 1'b1;
                q_wr_data.bytes[0] = poll_start_byte_reg;
                q_wr_data.bytes[1] = item.sensor_id;
            end
            default: q_wr_data = '0;
        endcase
    end

endmodule

// File: sv/tfe_queue.sv
module tfe_queue
#(
    parameter int unsigned DEPTH = tfe_pkg::QUEUE_DEPTH
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_en,
    input  tfe_pkg::frame_t wr_data,
    output logic            full,
    input  logic            rd_en,
    output tfe_pkg::frame_t rd_data,
    output logic            rd_valid
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    tfe_pkg::frame_t  slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;
    logic             do_wr;
    logic             do_rd;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = slot_reg[rd_ptr_reg];
    assign do_wr    = wr_en && !full;
    assign do_rd    = rd_en && rd_valid;

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Frame storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// File: sv/tfe_back.sv
module tfe_back
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_valid,
    input  tfe_pkg::frame_t  q_data,
    output logic             q_rd,
    output tfe_pkg::result_t result,
    output logic             empty,
    input  logic             pop
);

    logic [2:0]       idx_reg,  idx_next;
    logic             esc_reg,  esc_next;
    logic [7:0]       sum_reg,  sum_next;
    logic             out_valid_reg, out_valid_next;
    tfe_pkg::result_t out_reg,  out_next;

    logic       step;
    logic [7:0] cur_byte;
    logic       needs_stuff;
    logic       frame_last;
    logic [8:0] sum_wide;

    assign empty  = !out_valid_reg;
    assign result = out_reg;

    // Output register frees up when empty or being taken this cycle
    assign step = q_valid && (!out_valid_reg || pop);

    // Current unstuffed byte; the check byte is 0xFF minus the sum
    assign cur_byte = (!q_data.is_poll && (idx_reg == tfe_pkg::CHECK_IDX))
                      ? ~sum_reg : q_data.bytes[idx_reg];
    assign needs_stuff = !q_data.is_poll &&
                         ((cur_byte == tfe_pkg::FLAG_BYTE) || (cur_byte == tfe_pkg::ESC_BYTE));
    assign frame_last  = q_data.is_poll ? (idx_reg == tfe_pkg::POLL_LAST_IDX)
                                        : (idx_reg == tfe_pkg::CHECK_IDX);

    // End-around carry sum
    assign sum_wide = {1'b0, sum_reg} + {1'b0, cur_byte};

    // Byte sequencer
    always_comb
    begin
        idx_next       = idx_reg;
        esc_next       = esc_reg;
        sum_next       = sum_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !pop;
        q_rd           = 1'b0;
        if (step)
        begin
            out_valid_next = 1'b1;
            if (needs_stuff && !esc_reg)
            begin
                out_next.out_byte  = tfe_pkg::ESC_BYTE;
                out_next.last_byte = 1'b0;
                esc_next           = 1'b1;
            end
            else
            begin
                out_next.out_byte  = esc_reg ? (cur_byte ^ tfe_pkg::ESC_XOR) : cur_byte;
                out_next.last_byte = frame_last;
                esc_next           = 1'b0;
                sum_next           = sum_wide[7:0] + {7'd0, sum_wide[8]};
                idx_next           = idx_reg + 1'b1;
                if (frame_last)
                begin
                    idx_next = '0;
                    sum_next = '0;
                    q_rd     = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            esc_reg       <= 1'b0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            esc_reg       <= esc_next;
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

endmodule

// File: sv/telemetry_frame_encoder.sv
// Channel   Direction  Handshake             Payload
// item      in         push / full           tfe_pkg::item_t (kind, sensor_id, type_id, value)
// result    out        empty / pop           tfe_pkg::result_t (out_byte, last_byte)
// config    in         psel/penable/pwrite   APB, reg 0 at 0x0, reg 1 at 0x4, pready tied high
//
// One output byte per cycle while pop is held high and a frame is queued: a data frame is 8 to 16
// bytes on the line, an empty frame 8 to 10, a poll header 2; the byte sequencer in the back end emits them.
// The front end takes a new item every cycle while the frame queue has room.
// Reset empties the queue, clears the sequencer and the output valid flag, and loads register defaults.
// Holding pop low stalls the sequencer; items keep entering until the queue fills.
module telemetry_frame_encoder
#(
    parameter int unsigned QUEUE_DEPTH = tfe_pkg::QUEUE_DEPTH
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               push,
    output logic                               full,
    input  tfe_pkg::item_t                     item,
    output logic                               empty,
    input  logic                               pop,
    output tfe_pkg::result_t                   result,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [tfe_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [tfe_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [tfe_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                               pready
);

    logic            q_wr;
    logic            q_rd;
    logic            q_valid;
    tfe_pkg::frame_t q_wr_data;
    tfe_pkg::frame_t q_rd_data;

    assign pready = 1'b1;

    // Accept and classify
    tfe_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .item      (item),
        .q_full    (full),
        .q_wr      (q_wr),
        .q_wr_data (q_wr_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata)
    );

    // Frame queue between front and back
    tfe_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (q_wr),
        .wr_data  (q_wr_data),
        .full     (full),
        .rd_en    (q_rd),
        .rd_data  (q_rd_data),
        .rd_valid (q_valid)
    );

    // Stuff and serialize
    tfe_back u_back
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_data  (q_rd_data),
        .q_rd    (q_rd),
        .result  (result),
        .empty   (empty),
        .pop     (pop)
    );

endmodule

// File: dv/testbench.sv
`timescale 1ns / 100ps

module testbench;

    localparam int IDLE_PCT     = 26;
    localparam int SETTLE_TICKS = 40;
    localparam int STALL_LIMIT  = 2000;

    // Seven unstuffed bytes ahead of the check byte
    typedef logic [6:0][7:0] body_t;

    logic                           clk     = 1'b0;
    logic                           rst_n   = 1'b0;
    logic                           push    = 1'b0;
    logic                           full;
    tfe_pkg::item_t                 item    = '0;
    logic                           empty;
    logic                           pop     = 1'b0;
    tfe_pkg::result_t               result;
    logic                           psel    = 1'b0;
    logic                           penable = 1'b0;
    logic                           pwrite  = 1'b0;
    logic [tfe_pkg::CFG_ADDR_W-1:0] paddr   = '0;
    logic [tfe_pkg::CFG_DATA_W-1:0] pwdata  = '0;
    logic [tfe_pkg::CFG_DATA_W-1:0] prdata;
    logic                           pready;

    tfe_pkg::item_t   pending_items[$];
    tfe_pkg::result_t expected_bytes[$];
    logic [7:0]       frame_id_reg   = tfe_pkg::DATA_FRAME_ID_RST;
    logic [7:0]       poll_start_reg = tfe_pkg::POLL_START_BYTE_RST;
    logic             no_idle        = 1'b0;
    int               mismatch_count = 0;
    int               quiet_cycles   = 0;

    telemetry_frame_encoder DUT
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .item    (item),
        .empty   (empty),
        .pop     (pop),
        .result  (result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #1 clk = ~clk;

    // 8-bit add with end-around carry
    function automatic logic [7:0] ones_add(logic [7:0] acc, logic [7:0] b);
        logic [8:0] s;
        s = {1'b0, acc} + {1'b0, b};
        return s[7:0] + {7'd0, s[8]};
    endfunction

    function automatic body_t frame_body(tfe_pkg::item_t it, logic [7:0] frame_id);
        body_t b;
        b = '0;
        b[0] = frame_id;
        if (it.kind == tfe_pkg::KIND_DATA)
        begin
            b[1] = it.type_id[7:0];
            b[2] = it.type_id[15:8];
            for (int i = 0; i < 4; i++)
                b[3 + i] = it.value[8*i +: 8];
        end
        return b;
    endfunction

    function automatic logic [7:0] body_check(body_t b);
        logic [7:0] acc;
        acc = 8'h00;
        for (int i = 0; i < 7; i++)
            acc = ones_add(acc, b[i]);
        return 8'hFF - acc;
    endfunction

    // Escape flag and escape bytes on the line
    task automatic queue_stuffed(logic [7:0] b, logic last);
        if (b == tfe_pkg::FLAG_BYTE || b == tfe_pkg::ESC_BYTE)
        begin
            expected_bytes.push_back('{out_byte: tfe_pkg::ESC_BYTE, last_byte: 1'b0});
            expected_bytes.push_back('{out_byte: b ^ tfe_pkg::ESC_XOR, last_byte: last});
        end
        else
            expected_bytes.push_back('{out_byte: b, last_byte: last});
    endtask

    // Line bytes caused by one accepted item
    task automatic predict_frame(tfe_pkg::item_t it);
        body_t b;
        b = frame_body(it, frame_id_reg);
        case (it.kind)
            tfe_pkg::KIND_POLL:
            begin
                expected_bytes.push_back('{out_byte: poll_start_reg, last_byte: 1'b0});
                expected_bytes.push_back('{out_byte: it.sensor_id, last_byte: 1'b1});
            end
            tfe_pkg::KIND_UNUSED: ;
            default:
            begin
                for (int i = 0; i < 7; i++)
                    queue_stuffed(b[i], 1'b0);
                queue_stuffed(body_check(b), 1'b1);
            end
        endcase
    endtask

    // Payload byte biased toward the flag and escape values
    function automatic logic [7:0] rand_byte();
        case ($urandom_range(9))
            0: return tfe_pkg::FLAG_BYTE;
            1: return tfe_pkg::ESC_BYTE;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic tfe_pkg::item_t rand_item(logic [1:0] kind);
        tfe_pkg::item_t it;
        it.kind      = kind;
        it.sensor_id = rand_byte();
        it.type_id   = {rand_byte(), rand_byte()};
        it.value     = {rand_byte(), rand_byte(), rand_byte(), rand_byte()};
        return it;
    endfunction

    // Data frame whose check byte equals the target
    function automatic tfe_pkg::item_t data_with_check(logic [7:0] target);
        tfe_pkg::item_t it;
        it = rand_item(tfe_pkg::KIND_DATA);
        while (body_check(frame_body(it, frame_id_reg)) != target)
        begin
            it.type_id = 16'($urandom);
            it.value   = $urandom;
        end
        return it;
    endfunction

    task automatic queue_random_items(int count);
        tfe_pkg::item_t it;
        int             r;
        for (int n = 0; n < count; n++)
        begin
            r = $urandom_range(99);
            if (r < 45)
                it = rand_item(tfe_pkg::KIND_DATA);
            else if (r < 65)
                it = rand_item(tfe_pkg::KIND_EMPTY);
            else if (r < 90)
                it = rand_item(tfe_pkg::KIND_POLL);
            else
                it = rand_item(tfe_pkg::KIND_UNUSED);
            pending_items.push_back(it);
        end
    endtask

    // Wait until every beat is out, then give dropped items time to clear
    task automatic settle();
        while (pending_items.size() != 0 || push || expected_bytes.size() != 0)
            @(negedge clk);
        repeat (SETTLE_TICKS) @(negedge clk);
    endtask

    task automatic write_reg(logic idx, logic [7:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {24'($urandom), val};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == tfe_pkg::REG_DATA_FRAME_ID)
            frame_id_reg = val;
        else
            poll_start_reg = val;
        @(negedge clk);
    endtask

    // Item driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push <= 1'b0;
            item <= '0;
        end
        else
        begin
            if (push && !full)
            begin
                predict_frame(item);
                void'(pending_items.pop_front());
            end
            if (!push || !full)
            begin
                if (pending_items.size() != 0
                    && (no_idle || $urandom_range(99) >= IDLE_PCT))
                begin
                    push <= 1'b1;
                    item <= pending_items[0];
                end
                else
                    push <= 1'b0;
            end
        end
    end

    // Result monitor, with random back-pressure on pop
    always @(posedge clk or negedge rst_n)
    begin
        tfe_pkg::result_t want;
        if (!rst_n)
            pop <= 1'b0;
        else
        begin
            if (pop && !empty)
            begin
                if (expected_bytes.size() == 0)
                begin
                    $error("unexpected beat: out_byte %h last_byte %b",
                           result.out_byte, result.last_byte);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_bytes.pop_front();
                    if (result.out_byte !== want.out_byte)
                    begin
                        $error("out_byte: expected %h, actual %h",
                               want.out_byte, result.out_byte);
                        mismatch_count++;
                    end
                    if (result.last_byte !== want.last_byte)
                    begin
                        $error("last_byte: expected %b, actual %b",
                               want.last_byte, result.last_byte);
                        mismatch_count++;
                    end
                end
            end
            pop <= no_idle || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Watchdog on cycles with no beat on any port
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty) || (psel && penable))
                quiet_cycles <= 0;
            else if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("telemetry_frame_encoder: mismatch");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Stimulus
    initial
    begin
        tfe_pkg::item_t it;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed frames at register defaults
        pending_items.push_back('{kind: tfe_pkg::KIND_DATA, sensor_id: 8'h00,
                                  type_id: 16'h0000, value: 32'h0000_0000});
        pending_items.push_back('{kind: tfe_pkg::KIND_DATA, sensor_id: 8'hFF,
                                  type_id: 16'hFFFF, value: 32'hFFFF_FFFF});
        pending_items.push_back('{kind: tfe_pkg::KIND_DATA, sensor_id: 8'h5A,
                                  type_id: 16'h007E, value: 32'h7D7E_7D7E});
        pending_items.push_back('{kind: tfe_pkg::KIND_DATA, sensor_id: 8'hA5,
                                  type_id: 16'h7D7E, value: $urandom});
        pending_items.push_back('{kind: tfe_pkg::KIND_EMPTY, sensor_id: 8'h00,
                                  type_id: 16'h0000, value: 32'h0000_0000});
        pending_items.push_back('{kind: tfe_pkg::KIND_EMPTY, sensor_id: 8'hFF,
                                  type_id: 16'hFFFF, value: 32'hFFFF_FFFF});
        pending_items.push_back('{kind: tfe_pkg::KIND_POLL, sensor_id: 8'h00,
                                  type_id: 16'hFFFF, value: 32'hFFFF_FFFF});
        pending_items.push_back('{kind: tfe_pkg::KIND_POLL, sensor_id: 8'hFF,
                                  type_id: 16'h0000, value: 32'h0000_0000});
        // Poll bytes go out raw, even the flag and escape values
        pending_items.push_back('{kind: tfe_pkg::KIND_POLL, sensor_id: tfe_pkg::FLAG_BYTE,
                                  type_id: 16'h7E7E, value: 32'h7E7E_7E7E});
        pending_items.push_back('{kind: tfe_pkg::KIND_POLL, sensor_id: tfe_pkg::ESC_BYTE,
                                  type_id: 16'($urandom), value: $urandom});
        pending_items.push_back('{kind: tfe_pkg::KIND_UNUSED, sensor_id: 8'hFF,
                                  type_id: 16'hFFFF, value: 32'hFFFF_FFFF});
        pending_items.push_back(rand_item(tfe_pkg::KIND_UNUSED));
        // Stuffed check byte
        pending_items.push_back(data_with_check(tfe_pkg::FLAG_BYTE));
        pending_items.push_back(data_with_check(tfe_pkg::ESC_BYTE));
        pending_items.push_back(data_with_check(tfe_pkg::FLAG_BYTE));
        pending_items.push_back(rand_item(tfe_pkg::KIND_EMPTY));
        settle();

        // Frame id itself needs stuffing
        write_reg(tfe_pkg::REG_DATA_FRAME_ID, tfe_pkg::FLAG_BYTE);
        write_reg(tfe_pkg::REG_POLL_START_BYTE, 8'h00);
        queue_random_items(74);
        settle();

        // All-ones registers, no idling on either side
        write_reg(tfe_pkg::REG_DATA_FRAME_ID, 8'hFF);
        write_reg(tfe_pkg::REG_POLL_START_BYTE, 8'hFF);
        no_idle = 1'b1;
        queue_random_items(74);
        settle();
        no_idle = 1'b0;

        write_reg(tfe_pkg::REG_DATA_FRAME_ID, 8'h00);
        write_reg(tfe_pkg::REG_POLL_START_BYTE, tfe_pkg::ESC_BYTE);
        queue_random_items(74);
        settle();

        // Empty frames now end in a stuffed check byte
        write_reg(tfe_pkg::REG_DATA_FRAME_ID, 8'h81);
        write_reg(tfe_pkg::REG_POLL_START_BYTE, 8'($urandom));
        it = rand_item(tfe_pkg::KIND_EMPTY);
        pending_items.push_back(it);
        queue_random_items(74);
        settle();

        if (mismatch_count == 0)
            $display("telemetry_frame_encoder: match");
        else
            $display("telemetry_frame_encoder: mismatch");
        $finish;
    end

endmodule

// File: filelist.f
sv/tfe_pkg.sv
sv/tfe_front.sv
sv/tfe_queue.sv
sv/tfe_back.sv
sv/telemetry_frame_encoder.sv
dv/testbench.sv
